### sv/spas_pkg.sv
// Shared types and constants for the severity priority alarm selector.
package spas_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SLOT_W     = 3;
   localparam int SEV_W      = 8;
   localparam int TIME_W     = 32;
   localparam int REQ_W      = 2;

   localparam logic [SEV_W-1:0] BUZZ_THRESHOLD_RESET = 8'd200;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_SET     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SERVICE = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture the accepted item
      logic apply;      // perform set or clear on the addressed slot
      logic scan_clr;   // reset scan counter and winner tracking
      logic scan_step;  // visit one slot: expire and compare
      logic finish;     // drive the result strobe if a winner exists (for a service, only if a slot expired)
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_ok;     // item leads to a scan
      logic scan_last;  // current scan slot is the last one
   } status_type;

endpackage

### sv/spas_ctrl.sv
// Sequencing state machine of the alarm selector.
module spas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spas_pkg::status_type status,
   output spas_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_APPLY  = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (status.req_ok) begin
               cmd.apply    = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### sv/spas_dp.sv
// Slot table, scan unit and result register of the alarm selector.
module spas_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spas_pkg::cmd_type                    cmd,
   output spas_pkg::status_type                 status,
   input  logic [spas_pkg::REQ_W-1:0]           req_type,
   input  logic [spas_pkg::SLOT_W-1:0]          req_slot,
   input  logic [spas_pkg::SEV_W-1:0]           req_severity,
   input  logic [spas_pkg::TIME_W-1:0]          req_duration_ms,
   input  logic [spas_pkg::TIME_W-1:0]          req_now_ms,
   input  logic                                 csr_we,
   input  logic [spas_pkg::SEV_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   output logic [spas_pkg::SLOT_W-1:0]          rsp_shown_slot,
   output logic [spas_pkg::SEV_W-1:0]           rsp_shown_severity,
   output logic                                 rsp_buzz_start
);

   localparam int NS = spas_pkg::NUM_SLOTS;
   localparam int IW = spas_pkg::SLOT_IDX_W;

   // Captured item
   logic [spas_pkg::REQ_W-1:0]  req_type_ff;
   logic [spas_pkg::SLOT_W-1:0] slot_ff;
   logic [spas_pkg::SEV_W-1:0]  sev_ff;
   logic [spas_pkg::TIME_W-1:0] dur_ff;
   logic [spas_pkg::TIME_W-1:0] now_ff;

   // Slot table
   logic [NS-1:0]               active_ff;
   logic [spas_pkg::SEV_W-1:0]  sev_tab_ff [NS];
   logic [spas_pkg::TIME_W-1:0] dl_tab_ff  [NS];

   // Scan state
   logic [IW-1:0]               idx_ff;
   logic                        found_ff;
   logic                        expired_ff;
   logic [IW-1:0]               best_ff;
   logic [spas_pkg::SEV_W-1:0]  best_sev_ff;
   logic [IW-1:0]               shown_ff;
   logic [spas_pkg::SEV_W-1:0]  thr_ff;

   // Result register
   logic                        rsp_valid_ff;
   logic [spas_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [spas_pkg::SEV_W-1:0]  rsp_sev_ff;
   logic                        rsp_buzz_ff;

   logic [IW-1:0]               slot_idx;
   logic                        in_range;
   logic                        is_service;
   logic                        expire_hit;
   logic                        live;
   logic                        better;
   logic                        emit;

   assign slot_idx   = IW'(slot_ff);
   assign in_range   = (32'(slot_ff) < 32'(NS));
   assign is_service = (req_type_ff == spas_pkg::REQ_SERVICE);

   // Decide whether the item needs a scan
   always_comb begin
      status.req_ok    = 1'b0;
      status.scan_last = (32'(idx_ff) == 32'(NS - 1));
      case (req_type_ff)
         spas_pkg::REQ_SET:     status.req_ok = in_range;
         spas_pkg::REQ_CLEAR:   status.req_ok = in_range && active_ff[slot_idx];
         spas_pkg::REQ_SERVICE: status.req_ok = 1'b1;
         default:               status.req_ok = 1'b0;
      endcase
   end

   // Per-slot expiry and winner compare at the scan position
   assign expire_hit = is_service && active_ff[idx_ff] && (dl_tab_ff[idx_ff] != '0) &&
                       (now_ff >= dl_tab_ff[idx_ff]);
   assign live       = active_ff[idx_ff] && !expire_hit;
   assign better     = live && (!found_ff || (sev_tab_ff[idx_ff] > best_sev_ff));
   assign emit       = found_ff && (!is_service || expired_ff);

   // Item capture and slot table payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_type;
         slot_ff     <= req_slot;
         sev_ff      <= req_severity;
         dur_ff      <= req_duration_ms;
         now_ff      <= req_now_ms;
      end
      if (cmd.apply && (req_type_ff == spas_pkg::REQ_SET)) begin
         sev_tab_ff[slot_idx] <= sev_ff;
         dl_tab_ff[slot_idx]  <= (dur_ff != '0) ? (now_ff + dur_ff) : '0;
      end
      if (cmd.scan_clr) begin
         best_ff     <= '0;
         best_sev_ff <= '0;
      end else if (cmd.scan_step && better) begin
         best_ff     <= idx_ff;
         best_sev_ff <= sev_tab_ff[idx_ff];
      end
      if (cmd.finish) begin
         rsp_slot_ff <= spas_pkg::SLOT_W'(best_ff);
         rsp_sev_ff  <= best_sev_ff;
         rsp_buzz_ff <= (best_ff != shown_ff) && (best_sev_ff >= thr_ff);
      end
   end

   // Control state: active flags, scan flags, shown slot, threshold, strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         expired_ff   <= 1'b0;
         shown_ff     <= '0;
         thr_ff       <= spas_pkg::BUZZ_THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (cmd.apply) begin
            if (req_type_ff == spas_pkg::REQ_SET) begin
               active_ff[slot_idx] <= 1'b1;
            end else if (req_type_ff == spas_pkg::REQ_CLEAR) begin
               active_ff[slot_idx] <= 1'b0;
            end
         end
         if (cmd.scan_clr) begin
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            expired_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (expire_hit) begin
               active_ff[idx_ff] <= 1'b0;
               expired_ff        <= 1'b1;
            end
            if (better) begin
               found_ff <= 1'b1;
            end
         end
         rsp_valid_ff <= cmd.finish && emit;
         if (cmd.finish && emit) begin
            shown_ff <= best_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shown_slot     = rsp_slot_ff;
   assign rsp_shown_severity = rsp_sev_ff;
   assign rsp_buzz_start     = rsp_buzz_ff;

endmodule

### sv/severity_priority_alarm_selector_unit.sv
// Top level of the severity priority alarm selector.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  request  | start / busy        | req_type req_slot req_severity
//           |                     | req_duration_ms req_now_ms
//  result   | rsp_valid (strobe)  | rsp_shown_slot rsp_shown_severity
//           |                     | rsp_buzz_start
//  csr      | csr_we              | csr_wdata (buzz threshold)
//
// An item is taken when start is high and busy is low. A set, a clear of an
// active slot or a service runs a scan over all slots, one slot per cycle;
// rejected items return to idle without a scan. The result strobe is
// registered from the finish state that follows the scan and cannot be
// stalled. Synchronous reset clears all slots and restores the threshold.
module severity_priority_alarm_selector_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [spas_pkg::REQ_W-1:0]        req_type,
   input  logic [spas_pkg::SLOT_W-1:0]       req_slot,
   input  logic [spas_pkg::SEV_W-1:0]        req_severity,
   input  logic [spas_pkg::TIME_W-1:0]       req_duration_ms,
   input  logic [spas_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                              csr_we,
   input  logic [spas_pkg::SEV_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   output logic [spas_pkg::SLOT_W-1:0]       rsp_shown_slot,
   output logic [spas_pkg::SEV_W-1:0]        rsp_shown_severity,
   output logic                              rsp_buzz_start
);

   spas_pkg::cmd_type    cmd;
   spas_pkg::status_type status;

   spas_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   spas_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_slot           (req_slot),
      .req_severity       (req_severity),
      .req_duration_ms    (req_duration_ms),
      .req_now_ms         (req_now_ms),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_shown_slot     (rsp_shown_slot),
      .rsp_shown_severity (rsp_shown_severity),
      .rsp_buzz_start     (rsp_buzz_start)
   );

endmodule
